FILE: hw/rtl/touch_calibration_mapper_core_assert.svh
// Assertion macros for the touch calibration mapper core.
// Used by the top level; no other dependencies.
`ifndef TOUCH_CALIBRATION_MAPPER_CORE_ASSERT_SVH
`define TOUCH_CALIBRATION_MAPPER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TCM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TCM_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define TCM_ASSERT_IMPL(label, clk, rst_n, prop)
`define TCM_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/tcm_pkg.sv
// Shared types and constants for the touch calibration mapper.
// No dependencies.
`timescale 1ns / 1ps
package tcm_pkg;
    localparam int ADC_BITS = 10;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_LAND   = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [31:0] COEF_DEFAULT [7] = '{
        32'h00016440, 32'hFFFFD2A0, 32'hFAEC0868, 32'h00000080,
        32'h00022580, 32'hF8741560, 32'hFFFAB067
    };

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } t_div_rsp;
endpackage

FILE: hw/rtl/touch_calibration_mapper_core.sv
// Top level of the touch calibration mapper: sequencer, shared multiply-add,
// register file and output stage. Depends on tcm_pkg, tcm_divider and the assert header.
//
// Usage: items enter on the s_axis channel (tdata fields low to high: point_index,
// display_x, display_y, raw_x, raw_y, pressure; tuser carries cmd). Each item yields
// exactly one result transaction on m_axis (tdata fields low to high: pixel_x,
// pixel_y, echo_raw_x, echo_raw_y; tuser low to high: touch_valid, status).
// A load, an unused command, a sample below the threshold or a sample against a zero
// divider goes straight to the output stage; a compute runs 28 steps through the
// shared 32x32 multiply-accumulate; a touched sample runs two back-to-back passes
// of the bit-serial divider, started after the first two multiply-add steps.
// The block takes one item at a time; s_axis_tready is low from acceptance until
// the result transaction has been taken.
// If the receiver stalls, the result waits in the output register and no
// further item is accepted until it is taken.
// Reset is synchronous and active low; it restores register defaults and the
// built-in coefficient set. Calibration pairs hold no defined value until loaded.
// The APB port writes press_threshold, landscape_mode and display_height at
// addresses 0, 4 and 8; pready is tied high.
`timescale 1ns / 1ps
`include "touch_calibration_mapper_core_assert.svh"
module touch_calibration_mapper_core
    import tcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_index[1:0], display_x[11:2], display_y[21:12], raw_x, raw_y, pressure
    // (each ADC_BITS wide, following), zero padded to whole bytes
    input  logic [((22 + 3 * ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], echo_raw_x[41:32], echo_raw_y[51:42], pad
    output logic [55:0] m_axis_tdata,
    // touch_valid[0], status[1]
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RXL = 22;
    localparam int RYL = 22 + ADC_BITS;
    localparam int PRL = 22 + 2 * ADC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_CHECK, S_DIV_X, S_DIV_Y, S_SAMPLE, S_OUT
    } t_state;

    t_state      r_state;
    logic [9:0]  r_thresh;
    logic        r_land;
    logic [9:0]  r_height;
    logic [39:0] r_pairs [3];
    logic [31:0] r_coef [7];
    logic [31:0] r_new [7];
    logic [1:0]  r_cmd;
    logic [9:0]  r_rx, r_ry;
    logic [4:0]  r_step;
    logic [31:0] r_acc, r_qx, r_tmp;
    logic [32:0] r_px;
    logic        r_valid_o;
    logic [55:0] r_data_o;
    logic [1:0]  r_user_o;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    // Pair fields: dx [9:0], dy [19:10], rx [29:20], ry [39:30].
    function automatic logic [31:0] pf(input logic [39:0] p, input int k);
        return {22'd0, p[k*10 +: 10]};
    endfunction

    // Shared multiply-accumulate operand selection, one product per step.
    logic [31:0] w_ma, w_mb, w_prod;
    logic        w_neg, w_clr, w_tmp;
    logic [4:0]  w_dst;
    logic        w_wr;
    always_comb begin
        logic [31:0] sx02, sx12, sy02, sy12, dx02, dx12, dy02, dy12;
        logic [31:0] t0, t1, t2, t3;
        sx02 = pf(r_pairs[0], 2) - pf(r_pairs[2], 2);
        sx12 = pf(r_pairs[1], 2) - pf(r_pairs[2], 2);
        sy02 = pf(r_pairs[0], 3) - pf(r_pairs[2], 3);
        sy12 = pf(r_pairs[1], 3) - pf(r_pairs[2], 3);
        dx02 = pf(r_pairs[0], 0) - pf(r_pairs[2], 0);
        dx12 = pf(r_pairs[1], 0) - pf(r_pairs[2], 0);
        dy02 = pf(r_pairs[0], 1) - pf(r_pairs[2], 1);
        dy12 = pf(r_pairs[1], 1) - pf(r_pairs[2], 1);
        w_ma = '0; w_mb = '0; w_neg = 1'b0; w_clr = 1'b0; w_wr = 1'b0; w_dst = '0;
        w_tmp = 1'b0;
        t0 = '0; t1 = '0; t2 = '0; t3 = '0;
        if (r_cmd == CMD_COMPUTE) begin
            unique case (r_step)
                5'd0:  begin w_ma = sx02; w_mb = sy12; w_clr = 1'b1; end
                5'd1:  begin w_ma = sx12; w_mb = sy02; w_neg = 1'b1; w_wr = 1'b1; w_dst = 5'd6; end
                5'd2:  begin w_ma = dx02; w_mb = sy12; w_clr = 1'b1; end
                5'd3:  begin w_ma = dx12; w_mb = sy02; w_neg = 1'b1; w_wr = 1'b1; w_dst = 5'd0; end
                5'd4:  begin w_ma = sx02; w_mb = dx12; w_clr = 1'b1; end
                5'd5:  begin w_ma = dx02; w_mb = sx12; w_neg = 1'b1; w_wr = 1'b1; w_dst = 5'd1; end
                5'd6:  begin w_ma = dy02; w_mb = sy12; w_clr = 1'b1; end
                5'd7:  begin w_ma = dy12; w_mb = sy02; w_neg = 1'b1; w_wr = 1'b1; w_dst = 5'd3; end
                5'd8:  begin w_ma = sx02; w_mb = dy12; w_clr = 1'b1; end
                5'd9:  begin w_ma = dy02; w_mb = sx12; w_neg = 1'b1; w_wr = 1'b1; w_dst = 5'd4; end
                default: begin
                    // Constant terms C and F: per term the inner difference u*v - w*z
                    // is built in r_tmp over two steps, and a third step adds r_tmp*ry.
                    logic       k;
                    logic [1:0] a, b, c;
                    logic [4:0] s;
                    logic [3:0] s2;
                    s  = r_step - 5'd10;
                    k  = (s >= 5'd9);
                    s2 = k ? 4'(s - 5'd9) : s[3:0];
                    unique case (s2)
                        4'd0, 4'd1, 4'd2: begin a = 2'd2; b = 2'd1; c = 2'd0; end
                        4'd3, 4'd4, 4'd5: begin a = 2'd0; b = 2'd2; c = 2'd1; end
                        default:          begin a = 2'd1; b = 2'd0; c = 2'd2; end
                    endcase
                    unique case (s2)
                        4'd0, 4'd3, 4'd6: begin
                            w_ma = pf(r_pairs[a], 2);
                            w_mb = pf(r_pairs[b], int'(k));
                            w_clr = 1'b1;
                            w_tmp = 1'b1;
                        end
                        4'd1, 4'd4, 4'd7: begin
                            w_ma = pf(r_pairs[b], 2);
                            w_mb = pf(r_pairs[a], int'(k));
                            w_neg = 1'b1;
                            w_tmp = 1'b1;
                        end
                        default: begin
                            w_ma = r_tmp;
                            w_mb = pf(r_pairs[c], 3);
                            w_clr = (s2 == 4'd2);
                            w_wr = (s2 == 4'd8);
                            w_dst = k ? 5'd5 : 5'd2;
                        end
                    endcase
                end
            endcase
        end else begin
            unique case (r_step)
                5'd0: begin w_ma = r_coef[0]; w_mb = {22'd0, r_rx}; w_clr = 1'b1; end
                5'd1: begin w_ma = r_coef[1]; w_mb = {22'd0, r_ry}; end
                5'd2: begin w_ma = r_coef[3]; w_mb = {22'd0, r_rx}; w_clr = 1'b1; end
                default: begin w_ma = r_coef[4]; w_mb = {22'd0, r_ry}; end
            endcase
        end
    end
    assign w_prod = w_ma * w_mb;

    logic [31:0] w_acc;
    assign w_acc = (w_clr ? 32'd0 : (w_tmp ? r_tmp : r_acc)) +
                   (w_neg ? (32'd0 - w_prod) : w_prod);

    // The x division starts once its sum is complete; the y division follows
    // as soon as the x quotient is out.
    assign w_req.start    = ((r_state == S_SAMPLE) && (r_step == 5'd2)) ||
                            ((r_state == S_DIV_X) && w_rsp.done);
    assign w_req.dividend = (r_state == S_SAMPLE) ? r_qx : r_acc + r_coef[5];
    assign w_req.divisor  = r_coef[6];

    tcm_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    function automatic logic [15:0] sat16(input logic [33:0] v);
        if (!v[33] && v > 34'sd32767) return 16'h7FFF;
        if (v[33] && $signed(v) < -34'sd32768) return 16'h8000;
        return v[15:0];
    endfunction

    logic w_s_acc, w_cfg_wr;
    assign w_s_acc  = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr = psel && penable && pwrite;
    assign s_axis_tready = (r_state == S_IDLE) && !r_valid_o;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESH: prdata = {22'd0, r_thresh};
            REG_LAND:   prdata = {31'd0, r_land};
            REG_HEIGHT: prdata = {22'd0, r_height};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid_o <= 1'b0;
            r_thresh  <= 10'd100;
            r_land    <= 1'b0;
            r_height  <= 10'd240;
            r_step    <= '0;
            for (int i = 0; i < 7; i++) r_coef[i] <= COEF_DEFAULT[i];
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_THRESH: r_thresh <= pwdata[9:0];
                    REG_LAND:   r_land   <= pwdata[0];
                    REG_HEIGHT: r_height <= pwdata[9:0];
                    default:    ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_valid_o <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_s_acc) begin
                    logic [9:0] rx, ry, pr;
                    rx = 10'(s_axis_tdata[RXL +: ADC_BITS]);
                    ry = 10'(s_axis_tdata[RYL +: ADC_BITS]);
                    pr = 10'(s_axis_tdata[PRL +: ADC_BITS]);
                    r_cmd <= s_axis_tuser;
                    r_rx <= rx; r_ry <= ry;
                    r_step <= '0;
                    r_data_o <= '0;
                    r_user_o <= '0;
                    unique case (s_axis_tuser)
                        CMD_LOAD: begin
                            if (s_axis_tdata[1:0] != 2'd3)
                                r_pairs[s_axis_tdata[1:0]] <=
                                    {ry, rx, s_axis_tdata[21:12], s_axis_tdata[11:2]};
                            r_state <= S_OUT;
                        end
                        CMD_COMPUTE: r_state <= S_MAC;
                        CMD_SAMPLE: begin
                            if (pr < r_thresh) r_state <= S_OUT;
                            else begin
                                r_user_o[0] <= 1'b1;
                                r_data_o[51:32] <= {ry, rx};
                                if (r_coef[6] == 32'd0) begin
                                    r_user_o[1] <= 1'b1;
                                    r_state <= S_OUT;
                                end else r_state <= S_SAMPLE;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_MAC: begin
                    if (w_tmp) r_tmp <= w_acc;
                    else r_acc <= w_acc;
                    if (w_wr) r_new[w_dst[2:0]] <= w_acc;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd27) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_new[6] == 32'd0) r_user_o[1] <= 1'b1;
                    else for (int i = 0; i < 7; i++) r_coef[i] <= r_new[i];
                    r_state <= S_OUT;
                end
                S_SAMPLE: begin
                    if (r_step < 5'd4) r_acc <= w_acc;
                    if (r_step == 5'd1) r_qx <= w_acc + r_coef[2];
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd4) r_state <= S_DIV_X;
                end
                S_DIV_X: if (w_rsp.done) begin
                    r_px <= w_rsp.quotient;
                    r_state <= S_DIV_Y;
                end
                S_DIV_Y: if (w_rsp.done) begin
                    if (r_land) begin
                        r_data_o[15:0]  <= sat16({w_rsp.quotient[32], w_rsp.quotient});
                        r_data_o[31:16] <= sat16(34'({24'd0, r_height}) -
                                                 {r_px[32], r_px});
                    end else begin
                        r_data_o[15:0]  <= sat16({r_px[32], r_px});
                        r_data_o[31:16] <= sat16({w_rsp.quotient[32], w_rsp.quotient});
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid_o <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_valid_o;
    assign m_axis_tdata  = r_data_o;
    assign m_axis_tuser  = r_user_o;

    `TCM_ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, w_s_acc && (r_state != S_IDLE))
    `TCM_ASSERT_IMPL(a_out_from_seq, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
    `TCM_ASSERT_NEVER(a_inval_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata != '0))
endmodule

FILE: hw/rtl/tcm_divider.sv
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// Depends on tcm_pkg.
`timescale 1ns / 1ps
module tcm_divider
    import tcm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic        r_done;
    logic [32:0] w_trial;
    logic [32:0] w_shift;

    assign w_shift = {r_rem[31:0], r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_neg  <= i_req.dividend[31] ^ i_req.divisor[31];
                r_den  <= i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
                r_quo  <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (33'd0 - {1'b0, r_quo}) : {1'b0, r_quo};
endmodule

FILE: bench/touch_calibration_mapper_core_checker.sv
// Checker for the touch calibration mapper: watches the item, result and APB channels,
// predicts every result and compares it field by field. Depends on tcm_pkg only.
`timescale 1ns / 1ps
module touch_calibration_mapper_core_checker
    import tcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [55:0] i_s_data,
    input  logic [1:0]  i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [55:0] i_m_data,
    input  logic [1:0]  i_m_user,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_errors
);
    typedef struct {
        logic        touch_valid;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [9:0]  echo_x;
        logic [9:0]  echo_y;
        logic        status;
    } t_touch_result;

    t_touch_result pending_touch_q[$];

    logic [9:0]  threshold;
    logic        landscape;
    logic [9:0]  height;
    logic [9:0]  pair_dx [3];
    logic [9:0]  pair_dy [3];
    logic [9:0]  pair_rx [3];
    logic [9:0]  pair_ry [3];
    logic [31:0] coef [7];

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Derives the affine matrix from the three stored pairs in wrapping 32-bit math.
    // A zero divider keeps the old matrix and reports singular status.
    function automatic logic solve_matrix();
        logic [31:0] rx0, rx1, rx2, ry0, ry1, ry2, dx0, dx1, dx2, dy0, dy1, dy2;
        logic [31:0] sx02, sx12, sy02, sy12, ex02, ex12, ey02, ey12, det;
        rx0 = pair_rx[0]; rx1 = pair_rx[1]; rx2 = pair_rx[2];
        ry0 = pair_ry[0]; ry1 = pair_ry[1]; ry2 = pair_ry[2];
        dx0 = pair_dx[0]; dx1 = pair_dx[1]; dx2 = pair_dx[2];
        dy0 = pair_dy[0]; dy1 = pair_dy[1]; dy2 = pair_dy[2];
        sx02 = rx0 - rx2; sx12 = rx1 - rx2;
        sy02 = ry0 - ry2; sy12 = ry1 - ry2;
        ex02 = dx0 - dx2; ex12 = dx1 - dx2;
        ey02 = dy0 - dy2; ey12 = dy1 - dy2;
        det = sx02 * sy12 - sx12 * sy02;
        if (det == 32'd0) return 1'b1;
        coef[0] = ex02 * sy12 - ex12 * sy02;
        coef[1] = sx02 * ex12 - ex02 * sx12;
        coef[2] = (rx2 * dx1 - rx1 * dx2) * ry0 + (rx0 * dx2 - rx2 * dx0) * ry1
                + (rx1 * dx0 - rx0 * dx1) * ry2;
        coef[3] = ey02 * sy12 - ey12 * sy02;
        coef[4] = sx02 * ey12 - ey02 * sx12;
        coef[5] = (rx2 * dy1 - rx1 * dy2) * ry0 + (rx0 * dy2 - rx2 * dy0) * ry1
                + (rx1 * dy0 - rx0 * dy1) * ry2;
        coef[6] = det;
        return 1'b0;
    endfunction

    function automatic t_touch_result predict_touch(logic [1:0] cmd, logic [55:0] d);
        t_touch_result r;
        logic [31:0] rx, ry, sum_x, sum_y;
        longint qx, qy, t;
        r = '{default: '0};
        rx = d[31:22];
        ry = d[41:32];
        case (cmd)
            CMD_SAMPLE: begin
                if (d[51:42] >= threshold) begin
                    r.touch_valid = 1'b1;
                    r.echo_x = d[31:22];
                    r.echo_y = d[41:32];
                    if (coef[6] == 32'd0) begin
                        r.status = 1'b1;
                    end else begin
                        sum_x = coef[0] * rx + coef[1] * ry + coef[2];
                        sum_y = coef[3] * rx + coef[4] * ry + coef[5];
                        qx = longint'($signed(sum_x)) / longint'($signed(coef[6]));
                        qy = longint'($signed(sum_y)) / longint'($signed(coef[6]));
                        if (landscape) begin
                            t = qx;
                            qx = qy;
                            qy = longint'(height) - t;
                        end
                        r.pixel_x = clamp16(qx);
                        r.pixel_y = clamp16(qy);
                    end
                end
            end
            CMD_LOAD: begin
                if (d[1:0] < 2'd3) begin
                    pair_dx[d[1:0]] = d[11:2];
                    pair_dy[d[1:0]] = d[21:12];
                    pair_rx[d[1:0]] = d[31:22];
                    pair_ry[d[1:0]] = d[41:32];
                end
            end
            CMD_COMPUTE: r.status = solve_matrix();
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = pending_touch_q.size();

    always @(posedge i_clk) begin
        t_touch_result e;
        if (!i_rst_n) begin
            threshold = 10'd100;
            landscape = 1'b0;
            height = 10'd240;
            for (int i = 0; i < 7; i++) coef[i] = COEF_DEFAULT[i];
            for (int i = 0; i < 3; i++) begin
                pair_dx[i] = '0; pair_dy[i] = '0; pair_rx[i] = '0; pair_ry[i] = '0;
            end
            pending_touch_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_THRESH: threshold = i_pwdata[9:0];
                    REG_LAND:   landscape = i_pwdata[0];
                    REG_HEIGHT: height = i_pwdata[9:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready)
                pending_touch_q.push_back(predict_touch(i_s_user, i_s_data));
            if (i_m_valid && i_m_ready) begin
                if (pending_touch_q.size() == 0) begin
                    $error("result transaction with no item outstanding");
                    o_errors++;
                end else begin
                    e = pending_touch_q.pop_front();
                    check_field("touch_valid", e.touch_valid, i_m_user[0]);
                    check_field("status", e.status, i_m_user[1]);
                    check_field("pixel_x", $signed(e.pixel_x), $signed(i_m_data[15:0]));
                    check_field("pixel_y", $signed(e.pixel_y), $signed(i_m_data[31:16]));
                    check_field("echo_raw_x", e.echo_x, i_m_data[41:32]);
                    check_field("echo_raw_y", e.echo_y, i_m_data[51:42]);
                end
            end
        end
    end
endmodule

FILE: bench/touch_calibration_mapper_core_tb.sv
// Top of the touch calibration mapper bench: clock, reset, item and register stimulus,
// watchdog and verdict. Depends on tcm_pkg, the mapper core and the checker module.
`timescale 1ns / 1ps
module touch_calibration_mapper_core_tb;
    import tcm_pkg::*;

    localparam int STALL_LIMIT = 5000;
    // Longest internal latency is a valid sample; drain generously.
    localparam int DRAIN_CYCLES = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // point_index, display_x, display_y, raw_x, raw_y, pressure (low to high)
    logic [55:0] s_axis_tdata;
    // cmd
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // pixel_x, pixel_y, echo_raw_x, echo_raw_y (low to high)
    logic [55:0] m_axis_tdata;
    // touch_valid, status (low to high)
    logic [1:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending_touches;
    int mismatch_count;
    int send_gap_pct;
    int recv_stall_pct;
    int quiet_cycles;

    touch_calibration_mapper_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    touch_calibration_mapper_core_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_user(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_pending(pending_touches), .o_errors(mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver decides afresh at each edge whether it stalls.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: any transaction on the item, result or register channel clears it.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("touch_calibration_mapper_core verification failed");
            $finish;
        end
    end

    // Presents one item and holds it until the core takes it. The sender may
    // leave a random gap first; valid only drops when a gap really follows.
    task automatic send_item(logic [1:0] cmd, logic [1:0] idx, logic [9:0] dx,
                             logic [9:0] dy, logic [9:0] rx, logic [9:0] ry,
                             logic [9:0] pr);
        int gap;
        gap = 0;
        while (gap < 10 && $urandom_range(99) < send_gap_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'd0, pr, ry, rx, dy, dx, idx};
        @(posedge i_clk iff (s_axis_tvalid && s_axis_tready));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk iff (pending_touches == 0));
    endtask

    // One register write: setup phase, access phase, then an idle phase.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Registers change only with the core idle and its last result delivered.
    task automatic set_regs(logic [9:0] thr, logic land, logic [9:0] hgt);
        go_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_THRESH, {22'd0, thr});
        write_reg(REG_LAND, {31'd0, land});
        write_reg(REG_HEIGHT, {22'd0, hgt});
    endtask

    function automatic logic [9:0] rnd10();
        return 10'($urandom_range(1023));
    endfunction

    // Mostly calibration sessions with random content: three loads, a compute and
    // a burst of samples. Some sessions reuse a raw point so that the matrix is
    // singular, and a share of the traffic is random noise including unused codes.
    task automatic random_traffic(int count, int pause_at);
        int n, samples;
        logic [9:0] keep_x, keep_y;
        n = 0;
        while (n < count) begin
            if (pause_at >= 0 && n >= pause_at && n < pause_at + 12) begin
                go_idle();
                pause_at = -1;
            end
            if ($urandom_range(99) < 75) begin
                keep_x = rnd10();
                keep_y = rnd10();
                for (int p = 0; p < 3; p++) begin
                    if ($urandom_range(9) == 0)
                        send_item(CMD_LOAD, 2'(p), rnd10(), rnd10(), keep_x, keep_y, rnd10());
                    else
                        send_item(CMD_LOAD, 2'(p), rnd10(), rnd10(), rnd10(), rnd10(),
                                  rnd10());
                end
                send_item(CMD_COMPUTE, 2'($urandom_range(3)), rnd10(), rnd10(), rnd10(),
                          rnd10(), rnd10());
                samples = $urandom_range(8, 1);
                for (int s = 0; s < samples; s++)
                    send_item(CMD_SAMPLE, 2'($urandom_range(3)), rnd10(), rnd10(), rnd10(),
                              rnd10(), rnd10());
                n += 4 + samples;
            end else begin
                send_item(2'($urandom_range(3)), 2'($urandom_range(3)), rnd10(), rnd10(),
                          rnd10(), rnd10(), rnd10());
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= CMD_SAMPLE;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet_cycles <= 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset registers and the built-in matrix first:
        // samples just below and at the threshold, raw extremes, an unused
        // command and a load to the slot that does not exist.
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'd512, 10'd512, 10'd99);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'd512, 10'd512, 10'd100);
        send_item(CMD_SAMPLE, 2'd3, 10'h3ff, 10'h3ff, 10'd0, 10'd0, 10'h3ff);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'h3ff, 10'h3ff, 10'h3ff);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'h3ff, 10'h3ff, 10'd0);
        send_item(2'd3, 2'd1, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
        send_item(CMD_LOAD, 2'd3, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
        // A typical three-point calibration, then mapping at the raw corners.
        send_item(CMD_LOAD, 2'd0, 10'd32, 10'd32, 10'd100, 10'd100, 10'd0);
        send_item(CMD_LOAD, 2'd1, 10'd288, 10'd120, 10'd900, 10'd500, 10'd0);
        send_item(CMD_LOAD, 2'd2, 10'd160, 10'd208, 10'd500, 10'd900, 10'd0);
        send_item(CMD_COMPUTE, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3ff);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'h3ff, 10'h3ff, 10'h3ff);
        // Identical raw points make the divider zero; the matrix must survive.
        send_item(CMD_LOAD, 2'd0, 10'd0, 10'd0, 10'd400, 10'd400, 10'd0);
        send_item(CMD_LOAD, 2'd1, 10'h3ff, 10'd0, 10'd400, 10'd400, 10'd0);
        send_item(CMD_LOAD, 2'd2, 10'd0, 10'h3ff, 10'd400, 10'd400, 10'd0);
        send_item(CMD_COMPUTE, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'd300, 10'd700, 10'd500);
        // A steep matrix so that the raw extremes saturate in both directions.
        send_item(CMD_LOAD, 2'd0, 10'd0, 10'd0, 10'd500, 10'd500, 10'd0);
        send_item(CMD_LOAD, 2'd1, 10'h3ff, 10'd0, 10'd501, 10'd500, 10'd0);
        send_item(CMD_LOAD, 2'd2, 10'd0, 10'h3ff, 10'd500, 10'd501, 10'd0);
        send_item(CMD_COMPUTE, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3ff);
        send_item(CMD_SAMPLE, 2'd0, 10'd0, 10'd0, 10'h3ff, 10'h3ff, 10'h3ff);

        // Random phases, each under its own register setting and idling pattern.
        set_regs(10'd0, 1'b1, 10'h3ff);
        send_gap_pct = 36;
        recv_stall_pct = 60;
        random_traffic(150, -1);

        set_regs(10'h3ff, 1'b0, 10'd1);
        send_gap_pct = 60;
        recv_stall_pct = 36;
        random_traffic(150, -1);

        set_regs(10'd200, 1'b1, 10'd1);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        random_traffic(150, 70);

        set_regs(10'd50, 1'b0, 10'd500);
        random_traffic(150, -1);

        go_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_touches == 0)
            $display("touch_calibration_mapper_core verification clean");
        else
            $display("touch_calibration_mapper_core verification failed");
        $finish;
    end
endmodule
